// ===== hdl/ptb_pkg.sv =====
// Shared types and constants for the periodic timer bank.
`timescale 1ns / 1ps

package ptb_pkg;

    // default bank size and register reset value
    localparam int          TIMER_SLOTS_DEF = 16;
    localparam logic [31:0] HALF_WINDOW_RST = 32'h8000_0000;

    // command codes
    localparam logic [1:0] CMD_CREATE  = 2'd0;
    localparam logic [1:0] CMD_DELETE  = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;
    localparam logic [1:0] CMD_RUN     = 2'd3;

    // one entry of the slot data memory
    typedef struct packed {
        logic [15:0] period;
        logic [7:0]  id;
        logic        action;
        logic [31:0] deadline;
    } t_slot_word;

    // data memory port controls
    typedef struct packed {
        logic re;
        logic we;
    } t_data_ctl;

    // link memory port controls
    typedef struct packed {
        logic re;
        logic next_we;
        logic prev_we;
    } t_link_ctl;

endpackage

// ===== hdl/ptb_data_mem.sv =====
// Slot data memory: period, id, action flag and deadline, one read and one write port.
`timescale 1ns / 1ps

module ptb_data_mem
    import ptb_pkg::*;
#(
    parameter int SLOTS = TIMER_SLOTS_DEF
) (
    input  logic                       i_clk,
    input  t_data_ctl                  i_ctl,
    input  logic [$clog2(SLOTS)-1:0]   i_raddr,
    input  logic [$clog2(SLOTS)-1:0]   i_waddr,
    input  t_slot_word                 i_wdata,
    output t_slot_word                 o_rdata
);

    t_slot_word r_mem [SLOTS];
    t_slot_word r_rdata;

    // write, and register the read data when enabled
    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_ctl.re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/ptb_link_mem.sv =====
// Link memory: next and prev banks of the firing order, read together at one address.
`timescale 1ns / 1ps

module ptb_link_mem
    import ptb_pkg::*;
#(
    parameter int SLOTS = TIMER_SLOTS_DEF
) (
    input  logic                       i_clk,
    input  t_link_ctl                  i_ctl,
    input  logic [$clog2(SLOTS)-1:0]   i_raddr,
    input  logic [$clog2(SLOTS)-1:0]   i_next_waddr,
    input  logic [$clog2(SLOTS)-1:0]   i_next_wdata,
    input  logic [$clog2(SLOTS)-1:0]   i_prev_waddr,
    input  logic [$clog2(SLOTS)-1:0]   i_prev_wdata,
    output logic [$clog2(SLOTS)-1:0]   o_next,
    output logic [$clog2(SLOTS)-1:0]   o_prev
);

    localparam int SW = $clog2(SLOTS);

    logic [SW-1:0] r_next_mem [SLOTS];
    logic [SW-1:0] r_prev_mem [SLOTS];
    logic [SW-1:0] r_next;
    logic [SW-1:0] r_prev;

    // write each bank, register both reads when enabled
    always_ff @(posedge i_clk) begin
        if (i_ctl.next_we) begin
            r_next_mem[i_next_waddr] <= i_next_wdata;
        end
        if (i_ctl.prev_we) begin
            r_prev_mem[i_prev_waddr] <= i_prev_wdata;
        end
        if (i_ctl.re) begin
            r_next <= r_next_mem[i_raddr];
            r_prev <= r_prev_mem[i_raddr];
        end
    end

    assign o_next = r_next;
    assign o_prev = r_prev;

endmodule

// ===== hdl/ptb_ctrl.sv =====
// Command sequencer: list maintenance, expiry scan and result output register.
`timescale 1ns / 1ps

module ptb_ctrl
    import ptb_pkg::*;
#(
    parameter int SLOTS = TIMER_SLOTS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // command channel
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [1:0]                 i_command,
    input  logic [3:0]                 i_timer_slot,
    input  logic [7:0]                 i_timer_id,
    input  logic [15:0]                i_period,
    input  logic                       i_has_action,
    input  logic [31:0]                i_now_tick,
    // result channel
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [3:0]                 o_fired_slot,
    output logic [7:0]                 o_fired_id,
    output logic                       o_last,
    // configuration
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [31:0]                i_cfg_data,
    // data memory
    output t_data_ctl                  o_data_ctl,
    output logic [$clog2(SLOTS)-1:0]   o_data_raddr,
    output logic [$clog2(SLOTS)-1:0]   o_data_waddr,
    output t_slot_word                 o_data_wdata,
    input  t_slot_word                 i_data_rdata,
    // link memory
    output t_link_ctl                  o_link_ctl,
    output logic [$clog2(SLOTS)-1:0]   o_link_raddr,
    output logic [$clog2(SLOTS)-1:0]   o_next_waddr,
    output logic [$clog2(SLOTS)-1:0]   o_next_wdata,
    output logic [$clog2(SLOTS)-1:0]   o_prev_waddr,
    output logic [$clog2(SLOTS)-1:0]   o_prev_wdata,
    input  logic [$clog2(SLOTS)-1:0]   i_next,
    input  logic [$clog2(SLOTS)-1:0]   i_prev
);

    localparam int SW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_FLUSH = 3'd2;
    localparam logic [2:0] ST_DEL   = 3'd3;
    localparam logic [2:0] ST_RST   = 3'd4;

    // control state
    logic [2:0]       r_state, n_state;
    logic [SLOTS-1:0] r_active, n_active;
    logic [SW-1:0]    r_head, n_head;
    logic [SW-1:0]    r_tail, n_tail;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_idx, n_idx;
    logic [31:0]      r_half_window, n_half_window;
    logic             r_pend_v, n_pend_v;
    logic             r_out_v, n_out_v;

    // payload state
    logic [SW-1:0]    r_cur, n_cur;
    logic [SW-1:0]    r_slot, n_slot;
    logic [31:0]      r_now, n_now;
    logic [3:0]       r_pend_slot, n_pend_slot;
    logic [7:0]       r_pend_id, n_pend_id;
    logic [3:0]       r_out_slot, n_out_slot;
    logic [7:0]       r_out_id, n_out_id;
    logic             r_out_last, n_out_last;

    logic             accept;
    logic             slot_ok;
    logic [SW-1:0]    s_idx;
    logic             out_free;
    logic             expired;
    logic             fire;
    logic             hold;

    assign accept   = i_in_valid && (r_state == ST_IDLE);
    assign s_idx    = SW'(i_timer_slot);
    assign slot_ok  = 32'(i_timer_slot) < 32'(SLOTS);
    assign out_free = !r_out_v || !i_out_stall;
    assign expired  = (r_now - i_data_rdata.deadline) < r_half_window;
    assign fire     = expired && i_data_rdata.action;
    assign hold     = fire && r_pend_v && !out_free;

    always_comb begin
        n_state       = r_state;
        n_active      = r_active;
        n_head        = r_head;
        n_tail        = r_tail;
        n_count       = r_count;
        n_idx         = r_idx;
        n_half_window = r_half_window;
        n_pend_v      = r_pend_v;
        n_out_v       = r_out_v;
        n_cur         = r_cur;
        n_slot        = r_slot;
        n_now         = r_now;
        n_pend_slot   = r_pend_slot;
        n_pend_id     = r_pend_id;
        n_out_slot    = r_out_slot;
        n_out_id      = r_out_id;
        n_out_last    = r_out_last;

        o_data_ctl    = '0;
        o_data_raddr  = r_cur;
        o_data_waddr  = r_cur;
        o_data_wdata  = i_data_rdata;
        o_link_ctl    = '0;
        o_link_raddr  = r_cur;
        o_next_waddr  = r_tail;
        o_next_wdata  = s_idx;
        o_prev_waddr  = s_idx;
        o_prev_wdata  = r_tail;

        // take the window register
        if (i_cfg_valid) begin
            n_half_window = i_cfg_data;
        end

        // drop the result once taken
        if (r_out_v && !i_out_stall) begin
            n_out_v = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_now  = i_now_tick;
                    n_slot = s_idx;
                    case (i_command)
                        CMD_CREATE: begin
                            if (slot_ok) begin
                                // store slot data and arm it
                                o_data_ctl.we         = 1'b1;
                                o_data_waddr          = s_idx;
                                o_data_wdata.period   = i_period;
                                o_data_wdata.id       = i_timer_id;
                                o_data_wdata.action   = i_has_action;
                                o_data_wdata.deadline = i_now_tick + 32'(i_period);
                                // append to the firing order if new
                                if (!r_active[s_idx]) begin
                                    if (r_count == '0) begin
                                        n_head = s_idx;
                                    end else begin
                                        o_link_ctl.next_we = 1'b1;
                                        o_link_ctl.prev_we = 1'b1;
                                    end
                                    n_tail          = s_idx;
                                    n_active[s_idx] = 1'b1;
                                    n_count         = r_count + 1'b1;
                                end
                            end
                        end
                        CMD_DELETE: begin
                            if (slot_ok && r_active[s_idx]) begin
                                o_link_ctl.re = 1'b1;
                                o_link_raddr  = s_idx;
                                n_state       = ST_DEL;
                            end
                        end
                        CMD_RESTART: begin
                            if (slot_ok) begin
                                o_data_ctl.re = 1'b1;
                                o_data_raddr  = s_idx;
                                n_state       = ST_RST;
                            end
                        end
                        CMD_RUN: begin
                            if (r_count != '0) begin
                                o_data_ctl.re = 1'b1;
                                o_data_raddr  = r_head;
                                o_link_ctl.re = 1'b1;
                                o_link_raddr  = r_head;
                                n_cur         = r_head;
                                n_idx         = '0;
                                n_state       = ST_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_DEL: begin
                // unlink the slot between its neighbours
                if (r_head == r_slot) begin
                    n_head = i_next;
                end else begin
                    o_link_ctl.next_we = 1'b1;
                    o_next_waddr       = i_prev;
                    o_next_wdata       = i_next;
                end
                if (r_tail == r_slot) begin
                    n_tail = i_prev;
                end else begin
                    o_link_ctl.prev_we = 1'b1;
                    o_prev_waddr       = i_next;
                    o_prev_wdata       = i_prev;
                end
                n_active[r_slot] = 1'b0;
                n_count          = r_count - 1'b1;
                n_state          = ST_IDLE;
            end
            ST_RST: begin
                // rearm from the stored period
                o_data_ctl.we         = 1'b1;
                o_data_waddr          = r_slot;
                o_data_wdata.deadline = r_now + 32'(i_data_rdata.period);
                n_state               = ST_IDLE;
            end
            ST_SCAN: begin
                // visit one slot a cycle, stopping while both result stages are full and the slot fires
                if (!hold) begin
                    if (expired) begin
                        o_data_ctl.we         = 1'b1;
                        o_data_waddr          = r_cur;
                        o_data_wdata.deadline = r_now + 32'(i_data_rdata.period);
                    end
                    if (fire) begin
                        if (r_pend_v) begin
                            n_out_v    = 1'b1;
                            n_out_slot = r_pend_slot;
                            n_out_id   = r_pend_id;
                            n_out_last = 1'b0;
                        end
                        n_pend_v    = 1'b1;
                        n_pend_slot = 4'(r_cur);
                        n_pend_id   = i_data_rdata.id;
                    end
                    if ((r_idx + 1'b1) == r_count) begin
                        n_state = ST_FLUSH;
                    end else begin
                        n_idx         = r_idx + 1'b1;
                        n_cur         = i_next;
                        o_data_ctl.re = 1'b1;
                        o_data_raddr  = i_next;
                        o_link_ctl.re = 1'b1;
                        o_link_raddr  = i_next;
                    end
                end
            end
            ST_FLUSH: begin
                // release the held result as the last of the scan
                if (r_pend_v) begin
                    if (out_free) begin
                        n_out_v    = 1'b1;
                        n_out_slot = r_pend_slot;
                        n_out_id   = r_pend_id;
                        n_out_last = 1'b1;
                        n_pend_v   = 1'b0;
                        n_state    = ST_IDLE;
                    end
                end else begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_active      <= '0;
            r_head        <= '0;
            r_tail        <= '0;
            r_count       <= '0;
            r_idx         <= '0;
            r_half_window <= HALF_WINDOW_RST;
            r_pend_v      <= 1'b0;
            r_out_v       <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_active      <= n_active;
            r_head        <= n_head;
            r_tail        <= n_tail;
            r_count       <= n_count;
            r_idx         <= n_idx;
            r_half_window <= n_half_window;
            r_pend_v      <= n_pend_v;
            r_out_v       <= n_out_v;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cur       <= n_cur;
        r_slot      <= n_slot;
        r_now       <= n_now;
        r_pend_slot <= n_pend_slot;
        r_pend_id   <= n_pend_id;
        r_out_slot  <= n_out_slot;
        r_out_id    <= n_out_id;
        r_out_last  <= n_out_last;
    end

    assign o_in_stall   = (r_state != ST_IDLE);
    assign o_out_valid  = r_out_v;
    assign o_fired_slot = r_out_slot;
    assign o_fired_id   = r_out_id;
    assign o_last       = r_out_last;
    assign o_cfg_ready  = 1'b1;

endmodule

// ===== hdl/periodic_timer_bank.sv =====
// Create completes from the idle state; delete and restart also pass through the DEL or
// RST state (delete of an inactive slot does not). A run visits the active slots one slot
// per cycle, a rate set by the single read port of the slot data memory, and pauses only
// while the result output is stalled with a result already waiting and the slot fires.
// Results leave through an output register; the final one waits for the scan end.
// Reset (synchronous, active low) empties the firing order, the active flags and the
// result stages and restores the expiry window; the memories keep their contents.
`timescale 1ns / 1ps

module periodic_timer_bank
    import ptb_pkg::*;
#(
    parameter int TIMER_SLOTS = TIMER_SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_command,
    input  logic [3:0]  i_timer_slot,
    input  logic [7:0]  i_timer_id,
    input  logic [15:0] i_period,
    input  logic        i_has_action,
    input  logic [31:0] i_now_tick,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_fired_slot,
    output logic [7:0]  o_fired_id,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);

    localparam int SW = $clog2(TIMER_SLOTS);

    t_data_ctl  data_ctl;
    logic [SW-1:0] data_raddr;
    logic [SW-1:0] data_waddr;
    t_slot_word data_wdata;
    t_slot_word data_rdata;

    t_link_ctl  link_ctl;
    logic [SW-1:0] link_raddr;
    logic [SW-1:0] next_waddr;
    logic [SW-1:0] next_wdata;
    logic [SW-1:0] prev_waddr;
    logic [SW-1:0] prev_wdata;
    logic [SW-1:0] next_rd;
    logic [SW-1:0] prev_rd;

    ptb_data_mem #(
        .SLOTS (TIMER_SLOTS)
    ) u_data_mem (
        .i_clk   (i_clk),
        .i_ctl   (data_ctl),
        .i_raddr (data_raddr),
        .i_waddr (data_waddr),
        .i_wdata (data_wdata),
        .o_rdata (data_rdata)
    );

    ptb_link_mem #(
        .SLOTS (TIMER_SLOTS)
    ) u_link_mem (
        .i_clk        (i_clk),
        .i_ctl        (link_ctl),
        .i_raddr      (link_raddr),
        .i_next_waddr (next_waddr),
        .i_next_wdata (next_wdata),
        .i_prev_waddr (prev_waddr),
        .i_prev_wdata (prev_wdata),
        .o_next       (next_rd),
        .o_prev       (prev_rd)
    );

    ptb_ctrl #(
        .SLOTS (TIMER_SLOTS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_command    (i_command),
        .i_timer_slot (i_timer_slot),
        .i_timer_id   (i_timer_id),
        .i_period     (i_period),
        .i_has_action (i_has_action),
        .i_now_tick   (i_now_tick),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_fired_slot (o_fired_slot),
        .o_fired_id   (o_fired_id),
        .o_last       (o_last),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_data_ctl   (data_ctl),
        .o_data_raddr (data_raddr),
        .o_data_waddr (data_waddr),
        .o_data_wdata (data_wdata),
        .i_data_rdata (data_rdata),
        .o_link_ctl   (link_ctl),
        .o_link_raddr (link_raddr),
        .o_next_waddr (next_waddr),
        .o_next_wdata (next_wdata),
        .o_prev_waddr (prev_waddr),
        .o_prev_wdata (prev_wdata),
        .i_next       (next_rd),
        .i_prev       (prev_rd)
    );

endmodule

// ===== hdl/ptb_checker.sv =====
// Port-level checks for the periodic timer bank, bound to the top level.
`timescale 1ns / 1ps

module ptb_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [3:0] o_fired_slot,
    input logic [7:0] o_fired_id,
    input logic       o_last
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_fired_slot)
            && $stable(o_fired_id) && $stable(o_last)))
        else $error("stalled result changed");

    // a scan with results still to come keeps the command side stalled
    a_scan_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_last) |-> o_in_stall)
        else $error("command accepted while a scan was still delivering");

    // keep the handshake outputs known once out of reset
    a_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$isunknown({o_in_stall, o_out_valid}))
        else $error("handshake output unknown");

endmodule

bind periodic_timer_bank ptb_checker u_ptb_checker (.*);
